// ----- sv/tsg_pkg.sv -----
// shared constants, types and the quarter-wave sine rom for the tone sweep generator
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package tsg_pkg;

    // sine table and index sizing
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int INDEX_WIDTH      = 16;
    localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_AW           = SINE_AW - 2;
    localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;

    // field and register widths
    localparam int IDX_W        = 16;
    localparam int SAMPLE_W     = 16;
    localparam int START_W      = 31;
    localparam int CHIRP_W      = 48;
    localparam int CHIRP_HALF_W = CHIRP_W / 2;
    localparam int AMP_W        = 15;
    localparam int LEN_W        = 16;
    localparam int RECIP_W      = 17;
    localparam int ENV_W        = 17;
    localparam int PHASE_W      = 32;
    localparam int MAG_W        = 15;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_STAGES   = 7;

    localparam logic [ENV_W-1:0] ENV_FULL = 17'h10000;
    localparam logic [IDX_W-1:0] IDX_MASK =
        (INDEX_WIDTH >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((32'd1 << INDEX_WIDTH) - 32'd1);

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STEP = 3'd0,
        CFG_CHIRP_STEP = 3'd1,
        CFG_AMPLITUDE  = 3'd2,
        CFG_LENGTH     = 3'd3,
        CFG_FADE       = 3'd4,
        CFG_FADE_RECIP = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [START_W-1:0]        start_phase_step;
        logic signed [CHIRP_W-1:0] chirp_step;
        logic [AMP_W-1:0]          amplitude;
        logic [LEN_W-1:0]          length_samples;
        logic [LEN_W-1:0]          fade_samples;
        logic [RECIP_W-1:0]        fade_recip;
    } t_cfg;

    // per-stage load strobes and valid bits
    typedef struct packed {
        logic [NUM_STAGES:1] load;
        logic [NUM_STAGES:1] valid;
    } t_pipe_ctl;

    // quarter-wave sine, q30 taylor series to degree 13, scaled to 32767
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (v > 64'sd32767) begin
            v = 64'sd32767;
        end
        return v[MAG_W-1:0];
    endfunction

    typedef logic [MAG_W-1:0] t_qrom [QTR_DEPTH];

    function automatic t_qrom build_qrom();
        t_qrom rom;
        for (int j = 0; j < QTR_DEPTH; j++) begin
            rom[j] = quarter_sine(64'(j) << (PHASE_W - SINE_AW));
        end
        return rom;
    endfunction

    localparam t_qrom            QSINE_ROM = build_qrom();
    localparam logic [MAG_W-1:0] SINE_PEAK = quarter_sine(64'd1 << 30);

endpackage

// ----- sv/tsg_in_if.sv -----
// input channel of the tone sweep generator: valid, ready and the sample index
// depends on tsg_pkg
`timescale 1ns / 1ps

interface tsg_in_if;
    import tsg_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

// ----- sv/tsg_out_if.sv -----
// output channel of the tone sweep generator: valid, ready and one sample result
// depends on tsg_pkg
`timescale 1ns / 1ps

interface tsg_out_if;
    import tsg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;
    logic                       past_end;

    modport source (output valid, output sample_value, output last_sample, output past_end,
                    input ready);
    modport sink   (input valid, input sample_value, input last_sample, input past_end,
                    output ready);
endinterface

// ----- sv/tone_sweep_sample_generator_unit.sv -----
// tone and linear chirp sample generator: one signed 16-bit sample per sample index
// an accepted item passes through every pipeline stage in order before its result reaches the output channel
// throughput: one item per cycle while the output channel is not stalled; no stage iterates
// stalls: a per-stage ready chain fills empty stages while a finished result waits
// reset: synchronous active-low i_rst_n empties the pipeline and loads register defaults
`timescale 1ns / 1ps

module tone_sweep_sample_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tsg_in_if.sink                            i_in,
    tsg_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [tsg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tsg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tsg_pkg::*;

    t_cfg              r_cfg;
    t_cfg              n_cfg;
    t_pipe_ctl         w_ctl;
    logic              w_in_ready;
    logic [IDX_W-1:0]  w_index;

    // phase path to scale stage
    logic [QTR_AW-1:0] w_qidx;
    logic              w_peak;
    logic              w_neg;
    // envelope path to scale stage
    logic [ENV_W-1:0]  w_env;
    logic              w_past;
    logic              w_last;

    // configuration registers; the user must write them only while the pipeline is idle, the block does not enforce it
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_STEP: n_cfg.start_phase_step = i_cfg_data[START_W-1:0];
                CFG_CHIRP_STEP: n_cfg.chirp_step       = $signed(i_cfg_data[CHIRP_W-1:0]);
                CFG_AMPLITUDE:  n_cfg.amplitude        = i_cfg_data[AMP_W-1:0];
                CFG_LENGTH:     n_cfg.length_samples   = i_cfg_data[LEN_W-1:0];
                CFG_FADE:       n_cfg.fade_samples     = i_cfg_data[LEN_W-1:0];
                CFG_FADE_RECIP: n_cfg.fade_recip       = i_cfg_data[RECIP_W-1:0];
                default:        n_cfg = r_cfg;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_phase_step <= '0;
            r_cfg.chirp_step       <= '0;
            r_cfg.amplitude        <= '0;
            r_cfg.length_samples   <= LEN_W'(1);
            r_cfg.fade_samples     <= LEN_W'(1);
            r_cfg.fade_recip       <= ENV_FULL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // only the low INDEX_WIDTH index bits take part; with both widths at 16 that is all of them
    assign w_index = i_in.sample_index & IDX_MASK;

    // valid bits and stage load strobes
    tsg_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_ctl       (w_ctl)
    );

    // stages 1-4: phase accumulation and table folding
    tsg_phase u_phase (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_cfg   (r_cfg),
        .i_index (w_index),
        .o_qidx  (w_qidx),
        .o_peak  (w_peak),
        .o_neg   (w_neg)
    );

    // stages 1-4: fade envelope and end-of-segment flags
    tsg_env u_env (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_cfg   (r_cfg),
        .i_index (w_index),
        .o_env   (w_env),
        .o_past  (w_past),
        .o_last  (w_last)
    );

    // stages 5-7: rom read, two multiplies, exact divide and sign
    tsg_scale u_scale (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_cfg          (r_cfg),
        .i_qidx         (w_qidx),
        .i_peak         (w_peak),
        .i_neg          (w_neg),
        .i_env          (w_env),
        .i_past         (w_past),
        .i_last         (w_last),
        .o_sample_value (o_out.sample_value),
        .o_last         (o_out.last_sample),
        .o_past         (o_out.past_end)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_ctl.valid[NUM_STAGES];
endmodule

// ----- sv/tsg_pipe_ctrl.sv -----
// valid bits and per-stage ready chain for the seven-stage sample pipeline
// depends on tsg_pkg
`timescale 1ns / 1ps

module tsg_pipe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output tsg_pkg::t_pipe_ctl o_ctl
);
    import tsg_pkg::*;

    logic [NUM_STAGES:1]   r_valid;
    logic [NUM_STAGES:1]   n_valid;
    logic [NUM_STAGES+1:1] w_room;
    logic [NUM_STAGES:1]   w_feed;

    assign w_feed = {r_valid[NUM_STAGES-1:1], i_in_valid};

    // a stage may load when it is empty or its content moves on
    always_comb begin
        w_room[NUM_STAGES+1] = i_out_ready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            w_room[k] = !r_valid[k] || w_room[k+1];
        end
    end

    always_comb begin
        for (int k = 1; k <= NUM_STAGES; k++) begin
            n_valid[k] = w_room[k] ? w_feed[k] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = w_room[1];
    assign o_ctl.load  = w_room[NUM_STAGES:1];
    assign o_ctl.valid = r_valid;
endmodule

// ----- sv/tsg_phase.sv -----
// phase path, stages 1 to 4: n*start plus the chirp term, then quarter-wave folding
// depends on tsg_pkg; load strobes come from tsg_pipe_ctrl
`timescale 1ns / 1ps

module tsg_phase (
    input  logic                        i_clk,
    input  tsg_pkg::t_pipe_ctl          i_ctl,
    input  tsg_pkg::t_cfg               i_cfg,
    input  logic [tsg_pkg::IDX_W-1:0]   i_index,
    output logic [tsg_pkg::QTR_AW-1:0]  o_qidx,
    output logic                        o_peak,
    output logic                        o_neg
);
    import tsg_pkg::*;

    localparam int NN_W  = 2 * IDX_W;
    localparam int NS_W  = IDX_W + START_W;
    localparam int PLO_W = NN_W + CHIRP_HALF_W;

    // stage 1
    logic [NN_W-1:0]    r1_nn;
    logic [PHASE_W-1:0] r1_ns;
    logic [NN_W-1:0]    w_nn;
    logic [NS_W-1:0]    w_ns;
    // stage 2
    logic [CHIRP_W-1:0]      r2_plo;
    logic [CHIRP_HALF_W-1:0] r2_phi;
    logic [PHASE_W-1:0]      r2_ns;
    logic [PLO_W-1:0]        w_plo;
    logic [CHIRP_W-1:0]      w_phi;
    // stage 3
    logic [PHASE_W-1:0] r3_cp;
    logic [PHASE_W-1:0] r3_ns;
    logic [CHIRP_W-1:0] w_cp;
    // stage 4
    logic [PHASE_W-1:0] w_phase;
    logic [SINE_AW-1:0] w_addr;
    logic [1:0]         w_quad;
    logic [QTR_AW-1:0]  w_low;
    logic [QTR_AW-1:0]  w_mirror;
    logic [QTR_AW-1:0]  r4_qidx;
    logic               r4_peak;
    logic               r4_neg;

    assign w_nn = NN_W'(i_index) * NN_W'(i_index);
    assign w_ns = NS_W'(i_index) * NS_W'(i_cfg.start_phase_step);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r1_nn <= w_nn;
            r1_ns <= w_ns[PHASE_W-1:0];
        end
    end

    // chirp product split in two halves, only its low 48 bits matter
    assign w_plo = PLO_W'(r1_nn) * PLO_W'(i_cfg.chirp_step[CHIRP_HALF_W-1:0]);
    assign w_phi = CHIRP_W'(r1_nn[CHIRP_HALF_W-1:0])
                 * CHIRP_W'(i_cfg.chirp_step[CHIRP_W-1:CHIRP_HALF_W]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r2_plo <= w_plo[CHIRP_W-1:0];
            r2_phi <= w_phi[CHIRP_HALF_W-1:0];
            r2_ns  <= r1_ns;
        end
    end

    assign w_cp = r2_plo + {r2_phi, {CHIRP_HALF_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r3_cp <= w_cp[CHIRP_W-1:CHIRP_W-PHASE_W];
            r3_ns <= r2_ns;
        end
    end

    // top phase bits address the full table; fold onto the first quarter
    assign w_phase  = r3_ns + r3_cp;
    assign w_addr   = w_phase[PHASE_W-1 -: SINE_AW];
    assign w_quad   = w_addr[SINE_AW-1 -: 2];
    assign w_low    = w_addr[QTR_AW-1:0];
    assign w_mirror = ~w_low + 1'b1;  // quarter depth minus low

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r4_qidx <= w_quad[0] ? w_mirror : w_low;
            r4_peak <= w_quad[0] && (w_low == '0);
            r4_neg  <= w_quad[1];
        end
    end

    assign o_qidx = r4_qidx;
    assign o_peak = r4_peak;
    assign o_neg  = r4_neg;
endmodule

// ----- sv/tsg_env.sv -----
// fade envelope and end flags, stages 1 to 4, aligned with the phase path
// depends on tsg_pkg; load strobes come from tsg_pipe_ctrl
`timescale 1ns / 1ps

module tsg_env (
    input  logic                       i_clk,
    input  tsg_pkg::t_pipe_ctl         i_ctl,
    input  tsg_pkg::t_cfg              i_cfg,
    input  logic [tsg_pkg::IDX_W-1:0]  i_index,
    output logic [tsg_pkg::ENV_W-1:0]  o_env,
    output logic                       o_past,
    output logic                       o_last
);
    import tsg_pkg::*;

    localparam int EP_W = LEN_W + RECIP_W;

    logic [LEN_W:0]     w_next;
    logic [LEN_W:0]     w_reach;
    logic               w_past;
    logic               w_up;
    logic               w_down;
    logic [LEN_W-1:0]   r1_factor;
    logic               r1_full;
    logic               r1_past;
    logic               r1_last;
    logic [EP_W-1:0]    r2_prod;
    logic               r2_full;
    logic               r2_past;
    logic               r2_last;
    logic [ENV_W-1:0]   r3_env;
    logic               r3_past;
    logic               r3_last;
    logic [ENV_W-1:0]   r4_env;
    logic               r4_past;
    logic               r4_last;

    assign w_next  = (LEN_W+1)'(i_index) + 1'b1;
    assign w_reach = (LEN_W+1)'(i_index) + (LEN_W+1)'(i_cfg.fade_samples);
    assign w_past  = i_index >= i_cfg.length_samples;
    // rising ramp wins when both fades overlap
    assign w_up    = i_index < i_cfg.fade_samples;
    assign w_down  = (w_reach > (LEN_W+1)'(i_cfg.length_samples)) && !w_past;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r1_factor <= w_up ? i_index : i_cfg.length_samples - i_index;
            r1_full   <= !w_up && !w_down;
            r1_past   <= w_past;
            r1_last   <= w_next == (LEN_W+1)'(i_cfg.length_samples);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r2_prod <= EP_W'(r1_factor) * EP_W'(i_cfg.fade_recip);
            r2_full <= r1_full;
            r2_past <= r1_past;
            r2_last <= r1_last;
        end
    end

    // saturate at unity gain
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r3_env  <= (r2_full || (r2_prod > EP_W'(ENV_FULL))) ? ENV_FULL
                                                               : r2_prod[ENV_W-1:0];
            r3_past <= r2_past;
            r3_last <= r2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r4_env  <= r3_env;
            r4_past <= r3_past;
            r4_last <= r3_last;
        end
    end

    assign o_env  = r4_env;
    assign o_past = r4_past;
    assign o_last = r4_last;
endmodule

// ----- sv/tsg_scale.sv -----
// output stages 5 to 7: sine rom, amplitude times envelope times sine, divide by 32767*65536
// depends on tsg_pkg; load strobes come from tsg_pipe_ctrl
`timescale 1ns / 1ps

module tsg_scale (
    input  logic                                 i_clk,
    input  tsg_pkg::t_pipe_ctl                   i_ctl,
    input  tsg_pkg::t_cfg                        i_cfg,
    input  logic [tsg_pkg::QTR_AW-1:0]           i_qidx,
    input  logic                                 i_peak,
    input  logic                                 i_neg,
    input  logic [tsg_pkg::ENV_W-1:0]            i_env,
    input  logic                                 i_past,
    input  logic                                 i_last,
    output logic signed [tsg_pkg::SAMPLE_W-1:0]  o_sample_value,
    output logic                                 o_last,
    output logic                                 o_past
);
    import tsg_pkg::*;

    localparam int AE_W  = AMP_W + ENV_W;
    localparam int PR_W  = AE_W + MAG_W;
    localparam int X_W   = PR_W - 16;
    localparam int REM_W = SAMPLE_W + 1;
    localparam logic [REM_W-1:0] DIV_M  = 17'd32767;
    localparam logic [REM_W-1:0] DIV_2M = 17'd65534;

    logic [MAG_W-1:0]           r5_mag;
    logic [AE_W-1:0]            r5_ae;
    logic                       r5_neg;
    logic                       r5_past;
    logic                       r5_last;
    logic [PR_W-1:0]            r6_prod;
    logic                       r6_neg;
    logic                       r6_past;
    logic                       r6_last;
    logic [X_W-1:0]             w_x;
    logic [SAMPLE_W-1:0]        w_q1;
    logic [REM_W-1:0]           w_rem;
    logic [1:0]                 w_corr;
    logic [SAMPLE_W-1:0]        w_q;
    logic signed [SAMPLE_W-1:0] r7_value;
    logic                       r7_past;
    logic                       r7_last;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r5_mag  <= i_peak ? SINE_PEAK : QSINE_ROM[i_qidx];
            r5_ae   <= AE_W'(i_cfg.amplitude) * AE_W'(i_env);
            r5_neg  <= i_neg;
            r5_past <= i_past;
            r5_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            r6_prod <= PR_W'(r5_ae) * PR_W'(r5_mag);
            r6_neg  <= r5_neg;
            r6_past <= r5_past;
            r6_last <= r5_last;
        end
    end

    // x / (2^15 - 1): high part plus a remainder below three times the divisor
    assign w_x   = r6_prod[PR_W-1:16];
    assign w_q1  = w_x[X_W-1:15];
    assign w_rem = REM_W'(w_x[14:0]) + REM_W'(w_q1);

    always_comb begin
        priority if (w_rem >= DIV_2M) begin
            w_corr = 2'd2;
        end else if (w_rem >= DIV_M) begin
            w_corr = 2'd1;
        end else begin
            w_corr = 2'd0;
        end
    end

    assign w_q = w_q1 + SAMPLE_W'(w_corr);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[7]) begin
            if (r6_past) begin
                r7_value <= '0;
            end else if (r6_neg) begin
                r7_value <= -$signed(w_q);
            end else begin
                r7_value <= $signed(w_q);
            end
            r7_past <= r6_past;
            r7_last <= r6_last;
        end
    end

    assign o_sample_value = r7_value;
    assign o_last         = r7_last;
    assign o_past         = r7_past;
endmodule

// ----- sv/tsg_checker.sv -----
// port-level checks for the tone sweep generator and the bind that attaches them
// depends on tsg_pkg and tone_sweep_sample_generator_unit
`timescale 1ns / 1ps

module tsg_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [tsg_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                                i_last_sample,
    input  logic                                i_past_end
);
    import tsg_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // an item past the segment end is silent
    a_past_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_past_end |-> i_sample_value == '0)
        else $error("past_end item with nonzero sample");

    // the last sample lies inside the segment
    a_last_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_last_sample && i_past_end))
        else $error("last_sample and past_end both set");

    // magnitude never exceeds full scale, so the most negative code never shows
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_sample_value != SAMPLE_MIN)
        else $error("sample reached the most negative code");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample_value)
            && $stable(i_last_sample) && $stable(i_past_end))
        else $error("stalled result changed");
endmodule

bind tone_sweep_sample_generator_unit tsg_checker u_tsg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_sample_value (o_out.sample_value),
    .i_last_sample  (o_out.last_sample),
    .i_past_end     (o_out.past_end)
);
